// ===== src/lcc_pkg.sv =====
`timescale 1ns / 1ps

package lcc_pkg;

    // fixed field widths
    localparam int RANGE_W = 16;
    localparam int PT_W    = 20;   // cartesian point, quarter millimetres
    localparam int ANG_W   = 34;   // cordic x, y, z in q30
    localparam int JOB_IW  = 12;   // first sample index of a cluster
    localparam int JOB_CW  = 9;    // cluster point count
    localparam int IDX_W   = 13;   // first index plus offset
    localparam int MOD_STEPS = 12;
    localparam int CORDIC_STEPS = 30;

    localparam logic [47:0] TWO_PI_Q30 = 48'd6746518852;
    localparam logic [47:0] PI_Q30     = 48'd3373259426;
    localparam logic signed [ANG_W-1:0] PI_S      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_S = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] GAIN_S    = 34'sd652032874;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        last_sample;
    } t_in;

    typedef struct packed {
        logic signed [23:0] center_x_mm;
        logic signed [23:0] center_y_mm;
        logic [7:0]         object_number;
        logic               degenerate;
    } t_out;

    typedef struct packed {
        logic [15:0]        edge_threshold_mm;
        logic [15:0]        fill_threshold_mm;
        logic [15:0]        min_range_mm;
        logic [9:0]         side_margin;
        logic [10:0]        scan_length;
        logic signed [19:0] angle_start;
        logic [15:0]        angle_step;
        logic [7:0]         min_points;
    } t_cfg;

    typedef enum logic [3:0] {
        CFG_EDGE   = 4'd0,
        CFG_FILL   = 4'd1,
        CFG_MINRNG = 4'd2,
        CFG_MARGIN = 4'd3,
        CFG_SCANLN = 4'd4,
        CFG_ASTART = 4'd5,
        CFG_ASTEP  = 4'd6,
        CFG_MINPTS = 4'd7
    } t_cfg_idx;

    // closed cluster handed from segmentation to the fitter
    typedef struct packed {
        logic              valid;
        logic [JOB_IW-1:0] first;
        logic [JOB_CW-1:0] count;
        logic [7:0]        number;
    } t_job;

    typedef struct packed {
        logic               start;
        logic               div;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_mdu_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
    } t_mdu_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_OP,
        ST_MOD,
        ST_WRAP,
        ST_FOLD,
        ST_CORD,
        ST_CHECK,
        ST_DONE
    } t_fit_state;

    typedef enum logic [3:0] {
        OP_ANG,
        OP_PX,
        OP_PY,
        OP_T1,
        OP_T2,
        OP_A,
        OP_A2,
        OP_B,
        OP_C,
        OP_CY,
        OP_Q,
        OP_QD
    } t_op;

    function automatic logic signed [ANG_W-1:0] cordic_atan(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043837;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            default: v = 34'sd1 <<< (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

// ===== src/lcc_ram.sv =====
`timescale 1ns / 1ps

module lcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lcc_seg.sv =====
`timescale 1ns / 1ps

module lcc_seg #(
    parameter int MAX_SCAN      = 1024,
    parameter int MAX_POINTS    = 149,
    parameter int SEGMENT_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  lcc_pkg::t_in                     i_in,
    input  lcc_pkg::t_cfg                    i_cfg,
    output logic                             o_ram_we,
    output logic [$clog2(SEGMENT_DEPTH)-1:0] o_ram_waddr,
    output logic [15:0]                      o_ram_wdata,
    output lcc_pkg::t_job                    o_job
);

    import lcc_pkg::*;

    localparam int IW = $clog2(MAX_SCAN);
    localparam int CW = $clog2(MAX_POINTS + 2);
    localparam int AW = $clog2(SEGMENT_DEPTH);
    localparam int XW = CW + AW + 2;

    logic [IW-1:0] r_idx;
    logic [15:0]   r_prev;
    logic          r_fill;
    logic [15:0]   r_ref;
    logic          r_open;
    logic [IW-1:0] r_first;
    logic [CW-1:0] r_cnt;
    logic [7:0]    r_acc;

    logic          w_last;
    logic [15:0]   w_diff;
    logic          w_keep;
    logic          w_start;
    logic          w_marked;
    logic [13:0]   w_idx14;
    logic [CW-1:0] w_cnt_base;
    logic [CW-1:0] w_cnt_new;
    logic          w_open_new;
    logic          w_close;
    logic          w_ok;
    logic [7:0]    w_number;
    logic [IW-1:0] w_first_new;

    always_comb begin
        w_last  = i_in.last_sample || (r_idx >= IW'(MAX_SCAN - 1));
        w_diff  = (i_in.range_mm > r_ref) ? i_in.range_mm - r_ref : r_ref - i_in.range_mm;
        w_keep  = r_fill && (w_diff < i_cfg.fill_threshold_mm);
        w_idx14 = 14'(r_idx);
        w_start = !w_keep && (r_idx != '0)
               && (i_in.range_mm >= i_cfg.min_range_mm)
               && (w_idx14 >= 14'(i_cfg.side_margin))
               && (w_idx14 + 14'(i_cfg.side_margin) <= 14'(i_cfg.scan_length))
               && (r_prev >= i_in.range_mm)
               && ((r_prev - i_in.range_mm) >= i_cfg.edge_threshold_mm);
        w_marked   = w_keep || w_start;
        w_cnt_base = r_open ? r_cnt : '0;
        w_cnt_new  = w_cnt_base;
        if (w_marked && (XW'(w_cnt_base) < XW'(MAX_POINTS + 1))) begin
            w_cnt_new = w_cnt_base + CW'(1);
        end
        w_open_new  = r_open || w_marked;
        w_close     = w_open_new && (!w_marked || w_last);
        w_ok        = w_close && (XW'(w_cnt_new) > XW'(i_cfg.min_points))
                   && (XW'(w_cnt_new) <= XW'(MAX_POINTS));
        w_number    = (r_acc != 8'hFF) ? r_acc + 8'd1 : r_acc;
        w_first_new = r_open ? r_first : r_idx;
    end

    assign o_ram_we    = i_take && w_marked && (XW'(w_cnt_base) < XW'(SEGMENT_DEPTH));
    assign o_ram_waddr = AW'(w_cnt_base);
    assign o_ram_wdata = i_in.range_mm;

    always_comb begin
        o_job.valid  = i_take && w_ok;
        o_job.first  = JOB_IW'(w_first_new);
        o_job.count  = JOB_CW'(w_cnt_new);
        o_job.number = w_number;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_prev  <= '0;
            r_fill  <= 1'b0;
            r_ref   <= '0;
            r_open  <= 1'b0;
            r_first <= '0;
            r_cnt   <= '0;
            r_acc   <= '0;
        end else if (i_take) begin
            if (w_last) begin
                r_idx   <= '0;
                r_prev  <= '0;
                r_fill  <= 1'b0;
                r_ref   <= '0;
                r_open  <= 1'b0;
                r_first <= '0;
                r_cnt   <= '0;
                r_acc   <= '0;
            end else begin
                r_idx   <= r_idx + IW'(1);
                r_prev  <= i_in.range_mm;
                r_fill  <= w_marked;
                if (w_start) begin
                    r_ref <= i_in.range_mm;
                end
                r_open  <= w_open_new && !w_close;
                r_first <= w_first_new;
                r_cnt   <= w_cnt_new;
                if (w_ok) begin
                    r_acc <= w_number;
                end
            end
        end
    end

endmodule

// ===== src/lcc_mdu.sv =====
`timescale 1ns / 1ps

module lcc_mdu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcc_pkg::t_mdu_req i_req,
    output lcc_pkg::t_mdu_rsp o_rsp
);

    import lcc_pkg::*;

    logic        r_busy;
    logic        r_div;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic [63:0] r_ma;
    logic [63:0] r_mb;
    logic [64:0] r_acc;
    logic        r_done;
    logic signed [63:0] r_res;

    logic [64:0] w_rem_sh;
    logic        w_ge;
    logic [63:0] w_val;

    always_comb begin
        w_rem_sh = {r_acc[63:0], r_ma[63]};
        w_ge     = w_rem_sh >= {1'b0, r_mb};
        w_val    = r_div ? r_ma : r_acc[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 7'd64) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                end
            end
        end
    end

    // shift-add multiply or restoring divide on magnitudes, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_div <= i_req.div;
            r_neg <= i_req.a[63] ^ i_req.b[63];
            r_ma  <= i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
            r_mb  <= i_req.b[63] ? 64'(-i_req.b) : 64'(i_req.b);
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt == 7'd64) begin
                r_res <= r_neg ? -$signed(w_val) : $signed(w_val);
            end else if (r_div) begin
                r_acc <= w_ge ? w_rem_sh - {1'b0, r_mb} : w_rem_sh;
                r_ma  <= {r_ma[62:0], w_ge};
            end else begin
                r_acc <= {1'b0, r_acc[63:0] + (r_mb[0] ? r_ma : 64'd0)};
                r_ma  <= {r_ma[62:0], 1'b0};
                r_mb  <= {1'b0, r_mb[63:1]};
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.res  = r_res;
    end

endmodule

// ===== src/lcc_fit.sv =====
`timescale 1ns / 1ps

module lcc_fit #(
    parameter int SEGMENT_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lcc_pkg::t_job                    i_job,
    input  lcc_pkg::t_cfg                    i_cfg,
    output logic                             o_ram_re,
    output logic [$clog2(SEGMENT_DEPTH)-1:0] o_ram_raddr,
    input  logic [15:0]                      i_ram_rdata,
    output lcc_pkg::t_mdu_req                o_mdu_req,
    input  lcc_pkg::t_mdu_rsp                i_mdu_rsp,
    output logic                             o_busy,
    output logic                             o_valid,
    input  logic                             i_stall,
    output lcc_pkg::t_out                    o_out
);

    import lcc_pkg::*;

    localparam int AW = $clog2(SEGMENT_DEPTH);

    t_fit_state r_state, n_state;
    t_op        r_op;
    logic       r_issued;

    logic [JOB_IW-1:0] r_first;
    logic [JOB_CW-1:0] r_cnt;
    logic [7:0]        r_num;
    logic [1:0]        r_pt;
    logic [JOB_CW-1:0] r_off;
    logic              r_zneg;
    logic [47:0]       r_m;
    logic [3:0]        r_k;
    logic [4:0]        r_i;
    logic              r_flip;
    logic signed [ANG_W-1:0] r_x, r_y, r_zc;
    logic signed [PT_W-1:0]  r_px [3];
    logic signed [PT_W-1:0]  r_py [3];
    logic signed [63:0] r_t1, r_t2, r_a, r_b, r_c, r_cy, r_q;
    logic               r_deg;
    logic               r_out_valid;
    t_out               r_out;

    logic signed [63:0] w_x1, w_y1, w_x2, w_y2, w_x3, w_y3;
    logic signed [63:0] w_dx1, w_dy1, w_dx2, w_dy2;
    logic signed [63:0] w_den, w_num, w_den_new, w_u;
    logic signed [ANG_W-1:0] w_s, w_c;
    logic [15:0]  w_rng;
    logic         w_in_depth;
    logic [47:0]  w_sub;
    logic [47:0]  w_m2;
    logic signed [ANG_W-1:0] w_dxs, w_dys, w_atan;
    logic signed [63:0] w_ang;
    logic signed [63:0] w_two_cx, w_cxs;
    logic         w_load;
    logic [JOB_CW-1:0] w_off_next;

    always_comb begin
        w_x1 = {{(64-PT_W){r_px[0][PT_W-1]}}, r_px[0]};
        w_y1 = {{(64-PT_W){r_py[0][PT_W-1]}}, r_py[0]};
        w_x2 = {{(64-PT_W){r_px[1][PT_W-1]}}, r_px[1]};
        w_y2 = {{(64-PT_W){r_py[1][PT_W-1]}}, r_py[1]};
        w_x3 = {{(64-PT_W){r_px[2][PT_W-1]}}, r_px[2]};
        w_y3 = {{(64-PT_W){r_py[2][PT_W-1]}}, r_py[2]};
        w_dx1 = w_x2 - w_x1;
        w_dy1 = w_y2 - w_y1;
        w_dx2 = w_x3 - w_x2;
        w_dy2 = w_y3 - w_y2;
        w_den     = (r_t1 - r_t2) <<< 1;
        w_den_new = (r_t1 - i_mdu_rsp.res) <<< 1;
        w_num     = r_a + r_b - r_c;
        w_u       = (r_cy <<< 1) - (w_x1 + w_x2);
        w_s = r_flip ? -r_y : r_y;
        w_c = r_flip ? -r_x : r_x;
        w_in_depth = (10'(r_off) < 10'(SEGMENT_DEPTH));
        w_rng = w_in_depth ? i_ram_rdata : 16'd0;
        w_sub = TWO_PI_Q30 << r_k;
        w_m2  = (r_zneg && (r_m != '0)) ? TWO_PI_Q30 - r_m : r_m;
        w_dxs  = r_y >>> r_i;
        w_dys  = r_x >>> r_i;
        w_atan = cordic_atan(r_i);
        w_ang  = i_mdu_rsp.res + {{44{i_cfg.angle_start[19]}}, i_cfg.angle_start};
        w_two_cx = (w_y1 + w_y2) - r_q;
        w_cxs    = w_two_cx >>> 3;
        w_load   = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
        w_off_next = (r_pt == 2'd0) ? (r_cnt - JOB_CW'(1)) >> 1 : r_cnt - JOB_CW'(1);
    end

    // one multiply or divide at a time on the shared unit
    always_comb begin
        o_mdu_req.start = (r_state == ST_OP) && !r_issued;
        o_mdu_req.div   = 1'b0;
        o_mdu_req.a     = '0;
        o_mdu_req.b     = '0;
        case (r_op)
            OP_ANG: begin
                o_mdu_req.a = 64'(IDX_W'(r_first) + IDX_W'(r_off));
                o_mdu_req.b = {48'd0, i_cfg.angle_step};
            end
            OP_PX: begin
                o_mdu_req.a = {48'd0, w_rng};
                o_mdu_req.b = {{(64-ANG_W){w_s[ANG_W-1]}}, w_s};
            end
            OP_PY: begin
                o_mdu_req.a = {48'd0, w_rng};
                o_mdu_req.b = {{(64-ANG_W){w_c[ANG_W-1]}}, w_c};
            end
            OP_T1: begin
                o_mdu_req.a = w_dy2;
                o_mdu_req.b = w_dx1;
            end
            OP_T2: begin
                o_mdu_req.a = w_dy1;
                o_mdu_req.b = w_dx2;
            end
            OP_A: begin
                o_mdu_req.a = w_dy1;
                o_mdu_req.b = w_dy2;
            end
            OP_A2: begin
                o_mdu_req.a = r_a;
                o_mdu_req.b = w_y1 - w_y3;
            end
            OP_B: begin
                o_mdu_req.a = r_t1;
                o_mdu_req.b = w_x1 + w_x2;
            end
            OP_C: begin
                o_mdu_req.a = r_t2;
                o_mdu_req.b = w_x2 + w_x3;
            end
            OP_CY: begin
                o_mdu_req.div = 1'b1;
                o_mdu_req.a   = w_num;
                o_mdu_req.b   = w_den;
            end
            OP_Q: begin
                o_mdu_req.a = w_u;
                o_mdu_req.b = w_dx1;
            end
            OP_QD: begin
                o_mdu_req.div = 1'b1;
                o_mdu_req.a   = r_q;
                o_mdu_req.b   = w_dy1;
            end
            default: begin
                o_mdu_req.a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_job.valid) n_state = ST_ADDR;
            ST_ADDR:  n_state = ST_OP;
            ST_OP: begin
                if (i_mdu_rsp.done && r_issued) begin
                    unique case (r_op)
                        OP_ANG: n_state = ST_MOD;
                        OP_PX:  n_state = ST_OP;
                        OP_PY:  n_state = (r_pt == 2'd2) ? ST_CHECK : ST_ADDR;
                        OP_T2:  n_state = (w_den_new == '0) ? ST_DONE : ST_OP;
                        OP_QD:  n_state = ST_DONE;
                        default: n_state = ST_OP;
                    endcase
                end
            end
            ST_MOD:   if (r_k == 4'd0) n_state = ST_WRAP;
            ST_WRAP:  n_state = ST_FOLD;
            ST_FOLD:  n_state = ST_CORD;
            ST_CORD:  if (r_i == 5'(CORDIC_STEPS - 1)) n_state = ST_OP;
            ST_CHECK: begin
                if (w_dx1 == '0 || w_dx2 == '0 || w_dy1 == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_OP;
                end
            end
            ST_DONE:  if (w_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued <= 1'b0;
            r_op     <= OP_ANG;
        end else begin
            if (o_mdu_req.start) begin
                r_issued <= 1'b1;
            end else if (i_mdu_rsp.done) begin
                r_issued <= 1'b0;
            end
            if (r_state == ST_CHECK) begin
                r_op <= OP_T1;
            end else if (r_state == ST_ADDR) begin
                r_op <= OP_ANG;
            end else if (r_state == ST_CORD) begin
                r_op <= OP_PX;
            end else if (r_state == ST_OP && i_mdu_rsp.done && r_issued) begin
                case (r_op)
                    OP_PX:   r_op <= OP_PY;
                    OP_T1:   r_op <= OP_T2;
                    OP_T2:   r_op <= OP_A;
                    OP_A:    r_op <= OP_A2;
                    OP_A2:   r_op <= OP_B;
                    OP_B:    r_op <= OP_C;
                    OP_C:    r_op <= OP_CY;
                    OP_CY:   r_op <= OP_Q;
                    OP_Q:    r_op <= OP_QD;
                    default: r_op <= r_op;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_first <= i_job.first;
                r_cnt   <= i_job.count;
                r_num   <= i_job.number;
                r_pt    <= 2'd0;
                r_off   <= '0;
                r_deg   <= 1'b0;
            end
            ST_OP: begin
                if (i_mdu_rsp.done && r_issued) begin
                    case (r_op) inside
                        OP_ANG: begin
                            r_zneg <= (w_ang <<< 14) < 0;
                            r_m    <= 48'(((w_ang <<< 14) < 0) ? -(w_ang <<< 14)
                                                                :  (w_ang <<< 14));
                            r_k    <= 4'(MOD_STEPS - 1);
                        end
                        OP_PX: r_px[r_pt] <= PT_W'(i_mdu_rsp.res >>> 28);
                        OP_PY: begin
                            r_py[r_pt] <= PT_W'(i_mdu_rsp.res >>> 28);
                            r_pt       <= r_pt + 2'd1;
                            r_off      <= w_off_next;
                        end
                        OP_T1: r_t1 <= i_mdu_rsp.res;
                        OP_T2: begin
                            r_t2  <= i_mdu_rsp.res;
                            r_deg <= (w_den_new == '0);
                        end
                        OP_A, OP_A2: r_a <= i_mdu_rsp.res;
                        OP_B:  r_b <= i_mdu_rsp.res;
                        OP_C:  r_c <= i_mdu_rsp.res;
                        OP_CY: begin
                            if (i_mdu_rsp.res > 64'sd33554431) begin
                                r_cy <= 64'sd33554431;
                            end else if (i_mdu_rsp.res < -64'sd33554432) begin
                                r_cy <= -64'sd33554432;
                            end else begin
                                r_cy <= i_mdu_rsp.res;
                            end
                        end
                        OP_Q, OP_QD: r_q <= i_mdu_rsp.res;
                        default: r_q <= r_q;
                    endcase
                end
            end
            ST_MOD: begin
                if (r_m >= w_sub) begin
                    r_m <= r_m - w_sub;
                end
                r_k <= r_k - 4'd1;
            end
            ST_WRAP: begin
                r_zc <= (w_m2 >= PI_Q30) ? ANG_W'(w_m2 - TWO_PI_Q30) : ANG_W'(w_m2);
            end
            ST_FOLD: begin
                if (r_zc > HALF_PI_S) begin
                    r_zc   <= r_zc - PI_S;
                    r_flip <= 1'b1;
                end else if (r_zc < -HALF_PI_S) begin
                    r_zc   <= r_zc + PI_S;
                    r_flip <= 1'b1;
                end else begin
                    r_flip <= 1'b0;
                end
                r_x <= GAIN_S;
                r_y <= '0;
                r_i <= '0;
            end
            ST_CORD: begin
                if (r_zc >= 0) begin
                    r_x  <= r_x - w_dxs;
                    r_y  <= r_y + w_dys;
                    r_zc <= r_zc - w_atan;
                end else begin
                    r_x  <= r_x + w_dxs;
                    r_y  <= r_y - w_dys;
                    r_zc <= r_zc + w_atan;
                end
                r_i <= r_i + 5'd1;
            end
            ST_CHECK: begin
                r_deg <= (w_dx1 == '0 || w_dx2 == '0 || w_dy1 == '0);
            end
            default: begin
                r_pt <= r_pt;
            end
        endcase
    end

    // result register parts the fitter from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.object_number <= r_num;
            r_out.degenerate    <= r_deg;
            if (r_deg) begin
                r_out.center_x_mm <= '0;
                r_out.center_y_mm <= '0;
            end else begin
                if (w_cxs > 64'sd8388607) begin
                    r_out.center_x_mm <= 24'sd8388607;
                end else if (w_cxs < -64'sd8388608) begin
                    r_out.center_x_mm <= -24'sd8388608;
                end else begin
                    r_out.center_x_mm <= 24'(w_cxs);
                end
                r_out.center_y_mm <= 24'(r_cy >>> 2);
            end
        end
    end

    assign o_ram_re    = (r_state == ST_ADDR);
    assign o_ram_raddr = AW'(r_off);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== src/lidar_cluster_circle_center.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake                payload
// sample    in         i_valid / o_stall        i_in  (range_mm, last_sample)
// center    out        o_valid / i_stall        o_out (center x/y, number, degenerate)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a sample that closes no cluster starts no fit; the next sample is taken at once
// a sample that closes an accepted cluster starts a fit, o_stall high:
// per point an address, a multiply, 12-step modulo, wrap, fold, 30-step cordic, two multiplies,
// then nine multiply/divide steps; degenerate points or a zero denominator end it early
// sync active-low reset clears scan state and loads defaults; store needs no clearing pass
// a finished center waits in an output register; while it is stalled a second fit holds in its done state

module lidar_cluster_circle_center #(
    parameter int MAX_SCAN      = 1024,
    parameter int MAX_POINTS    = 149,
    parameter int SEGMENT_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lcc_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output lcc_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [3:0]    i_cfg_index,
    input  logic [19:0]   i_cfg_data
);

    import lcc_pkg::*;

    localparam int AW = $clog2(SEGMENT_DEPTH);

    t_cfg     r_cfg;
    t_job     w_job;
    t_mdu_req w_req;
    t_mdu_rsp w_rsp;
    logic          w_take;
    logic          w_fit_busy;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [15:0]   w_rdata;

    // config transaction, always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_threshold_mm <= 16'd600;
            r_cfg.fill_threshold_mm <= 16'd400;
            r_cfg.min_range_mm      <= 16'd250;
            r_cfg.side_margin       <= 10'd200;
            r_cfg.scan_length       <= 11'd666;
            r_cfg.angle_start       <= -20'sd125818;
            r_cfg.angle_step        <= 16'd377;
            r_cfg.min_points        <= 8'd9;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_EDGE:   r_cfg.edge_threshold_mm <= i_cfg_data[15:0];
                CFG_FILL:   r_cfg.fill_threshold_mm <= i_cfg_data[15:0];
                CFG_MINRNG: r_cfg.min_range_mm      <= i_cfg_data[15:0];
                CFG_MARGIN: r_cfg.side_margin       <= i_cfg_data[9:0];
                CFG_SCANLN: r_cfg.scan_length       <= i_cfg_data[10:0];
                CFG_ASTART: r_cfg.angle_start       <= $signed(i_cfg_data);
                CFG_ASTEP:  r_cfg.angle_step        <= i_cfg_data[15:0];
                CFG_MINPTS: r_cfg.min_points        <= i_cfg_data[7:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    // samples are held off only while a fit is in flight
    assign o_stall = w_fit_busy;
    assign w_take  = i_valid && !o_stall;

    // segmentation: edge detect, fill tracking, cluster bookkeeping
    lcc_seg #(
        .MAX_SCAN      (MAX_SCAN),
        .MAX_POINTS    (MAX_POINTS),
        .SEGMENT_DEPTH (SEGMENT_DEPTH)
    ) u_seg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_ram_we    (w_we),
        .o_ram_waddr (w_waddr),
        .o_ram_wdata (w_wdata),
        .o_job       (w_job)
    );

    // ranges of the open cluster
    lcc_ram #(
        .WIDTH (16),
        .DEPTH (SEGMENT_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer: angle, cordic, points, circle center
    lcc_fit #(
        .SEGMENT_DEPTH (SEGMENT_DEPTH)
    ) u_fit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_cfg       (r_cfg),
        .o_ram_re    (w_re),
        .o_ram_raddr (w_raddr),
        .i_ram_rdata (w_rdata),
        .o_mdu_req   (w_req),
        .i_mdu_rsp   (w_rsp),
        .o_busy      (w_fit_busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

    // shared bit-serial multiply / divide
    lcc_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // a closed cluster only arrives when the fitter can take it
    a_job_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job.valid |-> !w_fit_busy)
        else $error("cluster job while fitter busy");

    // degenerate results carry a zero center
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.degenerate) |-> (o_out.center_x_mm == '0 && o_out.center_y_mm == '0))
        else $error("degenerate result with nonzero center");

    // every reported object has a nonzero running number
    a_number_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.object_number != 8'd0))
        else $error("object number zero");

    // the multiply unit only answers while a fit is running
    a_mdu_in_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> w_fit_busy)
        else $error("multiply result outside a fit");

endmodule

// ===== tb/sv/lidar_cluster_circle_center_test.sv =====
`timescale 1ns / 1ps

module lidar_cluster_circle_center_test;
    import lcc_pkg::*;

    // generous cycle limit: ~1550 samples, even if every one started a fit,
    // receiver stalls on top, taken several times over
    localparam int LIMIT = 12000000;
    localparam int SCAN_MAX = 1024;
    localparam int PTS_MAX = 149;
    localparam int STORE_DEPTH = 256;
    localparam int FIT_SETTLE = 1200;

    localparam longint TWO_PI_U = 64'sd6746518852;
    localparam longint PI_U = 64'sd3373259426;
    localparam longint HALF_PI_U = 64'sd1686629713;
    localparam longint GAIN_U = 64'sd652032874;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    t_in i_in;
    t_out o_out;
    logic i_cfg_valid, o_cfg_ready;
    logic [3:0] i_cfg_index;
    logic [19:0] i_cfg_data;

    lidar_cluster_circle_center dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_in(i_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // segmentation and circle-fit predictor
    // ---------------------------------------------------------------
    t_cfg regs;                          // predictor's copy of the registers
    int unsigned seg_idx, prev_rng, ref_rng, first_idx, pt_count, obj_count;
    bit in_fill, seg_open;
    logic [15:0] seg_store [STORE_DEPTH];

    t_out centers_due[$];                // centers still owed by the block
    int errors, n_samples, n_centers, n_degen, n_writes;
    int sender_pct, receiver_pct;        // idle odds, percent of cycles

    longint atan_q30 [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                              33543516, 16775851, 8388437, 4194283, 2097149};

    function automatic void clear_scan_state();
        seg_idx = 0; prev_rng = 0; ref_rng = 0; in_fill = 0; seg_open = 0;
        first_idx = 0; pt_count = 0; obj_count = 0;
    endfunction

    // 30-step cordic, angle in 2^-16 rad, sin/cos in q30
    function automatic void sin_cos(input longint ang16, output longint s, output longint c);
        longint z, x, y, a, dx, dy;
        bit flip;
        z = (ang16 * 16384) % TWO_PI_U;
        x = GAIN_U; y = 0; flip = 0;
        if (z >= PI_U) z -= TWO_PI_U;
        if (z < -PI_U) z += TWO_PI_U;
        if (z > HALF_PI_U) begin
            z -= PI_U; flip = 1;
        end else if (z < -HALF_PI_U) begin
            z += PI_U; flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            a = (i < 10) ? atan_q30[i] : (64'sd1 <<< (30 - i));
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= a;
            end else begin
                x += dx; y -= dy; z += a;
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // cartesian point of a cluster sample, quarter millimetres
    function automatic void seg_point(input int unsigned off, output longint px,
                                      output longint py);
        longint r, s, c;
        r = (off < STORE_DEPTH) ? longint'(seg_store[off]) : 0;
        sin_cos(longint'(regs.angle_start) + longint'(first_idx + off) *
                longint'(regs.angle_step), s, c);
        px = (r * s) >>> 28;
        py = (r * c) >>> 28;
    endfunction

    function automatic bit fit_center(output longint cx, output longint cy);
        longint x1, y1, x2, y2, x3, y3, dx1, dy1, dx2, dy2, den, num, q;
        seg_point(0, x1, y1);
        seg_point((pt_count - 1) / 2, x2, y2);
        seg_point(pt_count - 1, x3, y3);
        dx1 = x2 - x1; dy1 = y2 - y1; dx2 = x3 - x2; dy2 = y3 - y2;
        cx = 0; cy = 0;
        if (dx1 == 0 || dx2 == 0 || dy1 == 0) return 1;
        den = 2 * (dy2 * dx1 - dy1 * dx2);
        if (den == 0) return 1;
        num = dy1 * dy2 * (y1 - y3) + dy2 * dx1 * (x1 + x2) - dy1 * dx2 * (x2 + x3);
        cy = num / den;
        if (cy > (64'sd1 <<< 25) - 1) cy = (64'sd1 <<< 25) - 1;
        if (cy < -(64'sd1 <<< 25)) cy = -(64'sd1 <<< 25);
        q = ((2 * cy - (x1 + x2)) * dx1) / dy1;
        cx = ((y1 + y2) - q) >>> 3;
        if (cx > 8388607) cx = 8388607;
        if (cx < -8388608) cx = -8388608;
        cy = cy >>> 2;
        return 0;
    endfunction

    // advance the predictor by one sample; returns 1 when a center is due
    function automatic bit segment_sample(input t_in smp, output t_out ctr);
        int unsigned r, diff;
        bit last, marked, start;
        longint cx, cy;
        r = smp.range_mm;
        last = smp.last_sample || (seg_idx >= SCAN_MAX - 1);
        marked = 0;
        segment_sample = 0;
        ctr = '0;
        if (in_fill) begin
            diff = (r > ref_rng) ? r - ref_rng : ref_rng - r;
            if (diff < regs.fill_threshold_mm) marked = 1;
            else in_fill = 0;
        end
        if (!marked) begin
            start = seg_idx >= 1 && r >= regs.min_range_mm &&
                    int'(seg_idx) >= int'(regs.side_margin) &&
                    int'(seg_idx) <= int'(regs.scan_length) - int'(regs.side_margin) &&
                    int'(prev_rng) - int'(r) >= int'(regs.edge_threshold_mm);
            if (start) begin
                marked = 1; in_fill = 1; ref_rng = r;
            end
        end
        if (marked) begin
            if (!seg_open) begin
                seg_open = 1; first_idx = seg_idx; pt_count = 0;
            end
            if (pt_count < STORE_DEPTH) seg_store[pt_count] = r[15:0];
            if (pt_count < PTS_MAX + 1) pt_count++;
        end
        if (seg_open && (!marked || last)) begin
            seg_open = 0;
            if (pt_count > regs.min_points && pt_count <= PTS_MAX) begin
                ctr.degenerate = fit_center(cx, cy);
                if (obj_count < 255) obj_count++;
                ctr.center_x_mm = cx[23:0];
                ctr.center_y_mm = cy[23:0];
                ctr.object_number = obj_count[7:0];
                segment_sample = 1;
            end
        end
        prev_rng = r;
        seg_idx++;
        if (last) clear_scan_state();
    endfunction

    // ---------------------------------------------------------------
    // mismatch reporting and output checking
    // ---------------------------------------------------------------
    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("[%0t] center %0d: %s got %0d want %0d", $time, n_centers, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_out want;
            if (centers_due.size() == 0) begin
                report("unexpected transaction, object_number", o_out.object_number, 0);
            end else begin
                want = centers_due.pop_front();
                if (o_out.center_x_mm !== want.center_x_mm)
                    report("center_x_mm", o_out.center_x_mm, want.center_x_mm);
                if (o_out.center_y_mm !== want.center_y_mm)
                    report("center_y_mm", o_out.center_y_mm, want.center_y_mm);
                if (o_out.object_number !== want.object_number)
                    report("object_number", o_out.object_number, want.object_number);
                if (o_out.degenerate !== want.degenerate)
                    report("degenerate", o_out.degenerate, want.degenerate);
                if (want.degenerate) n_degen++;
            end
            n_centers++;
        end
    end

    // receiver backpressure, odds set per phase
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99, 0) < receiver_pct);
    end

    // watchdog
    int cycles;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sample and register drivers
    // ---------------------------------------------------------------
    // one sample transaction; a typed center replaces the predicted one
    task automatic send_sample(input t_in smp, input bit typed = 0, input t_out typed_ctr = '0);
        t_out ctr;
        if ($urandom_range(99, 0) < sender_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < sender_pct);
        end
        i_valid <= 1'b1;
        i_in <= smp;
        do @(posedge i_clk); while (o_stall);
        n_samples++;
        if (segment_sample(smp, ctr)) centers_due = {centers_due, typed ? typed_ctr : ctr};
    endtask

    task automatic end_samples();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain, let the block settle, then load all registers
    task automatic load_registers(input t_cfg c);
        logic [19:0] val [8];
        t_cfg_idx ix;
        while (centers_due.size() != 0) @(posedge i_clk);
        repeat (FIT_SETTLE) @(posedge i_clk);
        val[CFG_EDGE] = c.edge_threshold_mm;
        val[CFG_FILL] = c.fill_threshold_mm;
        val[CFG_MINRNG] = c.min_range_mm;
        val[CFG_MARGIN] = c.side_margin;
        val[CFG_SCANLN] = c.scan_length;
        val[CFG_ASTART] = c.angle_start;
        val[CFG_ASTEP] = c.angle_step;
        val[CFG_MINPTS] = c.min_points;
        for (int k = 0; k < 8; k++) begin
            ix = t_cfg_idx'(k);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= ix;
            i_cfg_data <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            n_writes++;
        end
        i_cfg_valid <= 1'b0;
        regs = c;
    endtask

    function automatic logic [15:0] clip16(input longint v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hffff;
        return v[15:0];
    endfunction

    // one scan: background with dropped objects, some noise, last flag at the end
    task automatic run_scan(input int len);
        logic [15:0] rq[$];
        longint bg, ref_v, jit;
        int n;
        bg = $urandom_range(40000, 3000);
        while (rq.size() < len) begin
            case ($urandom_range(11, 0)) inside
                0: rq = {rq, 16'($urandom())};
                [1:6]: begin
                    // well-formed object: edge drop, fill inside the threshold, rise back
                    ref_v = longint'(regs.min_range_mm) + $urandom_range(3000, 0);
                    bg = ref_v + regs.edge_threshold_mm + $urandom_range(2000, 0);
                    if (bg > 65535) begin
                        bg = 65535;
                        ref_v = bg - regs.edge_threshold_mm;
                    end
                    rq = {rq, clip16(bg)};
                    rq = {rq, clip16(ref_v)};
                    n = ($urandom_range(14, 0) == 0) ? $urandom_range(160, 140)
                                                     : $urandom_range(25, 1);
                    for (int k = 1; k < n; k++) begin
                        jit = (regs.fill_threshold_mm == 0) ? 0 :
                              $urandom_range(regs.fill_threshold_mm - 1, 0);
                        rq = {rq, clip16($urandom_range(1, 0) ? ref_v + jit : ref_v - jit)};
                    end
                    rq = {rq, clip16(bg)};
                end
                default: rq = {rq, clip16(bg + $urandom_range(200, 0) - 100)};
            endcase
        end
        for (int k = 0; k < len; k++) send_sample('{range_mm: rq[k], last_sample: k == len - 1});
    endtask

    function automatic t_cfg random_regs();
        t_cfg c;
        c.edge_threshold_mm = $urandom_range(1500, 300);
        c.fill_threshold_mm = $urandom_range(800, 100);
        c.min_range_mm = $urandom_range(500, 0);
        c.side_margin = $urandom_range(15, 0);
        c.scan_length = $urandom_range(300, 100);
        c.angle_start = $signed($urandom_range(823550, 0)) - 411775;
        c.angle_step = $urandom_range(1, 0) ? $urandom_range(2000, 1) : $urandom();
        c.min_points = $urandom_range(12, 0);
        return c;
    endfunction

    task automatic run_phase(input t_cfg c, input int samples);
        int stop;
        load_registers(c);
        stop = n_samples + samples;
        while (n_samples < stop) run_scan($urandom_range(60, 10));
        end_samples();
    endtask

    // ---------------------------------------------------------------
    // directed scans: zero-range object, scan end with an open cluster,
    // single-sample scan, too-short cluster, extreme ranges
    // ---------------------------------------------------------------
    typedef struct {
        logic [15:0] rng;
        bit          last;
        bit          typed;
        t_out        ctr;
    } t_row;

    t_row rows [21] = '{
        '{1000, 0, 0, '0}, '{0, 0, 0, '0}, '{0, 0, 0, '0}, '{0, 0, 0, '0},
        '{1000, 0, 1, '{center_x_mm: 0, center_y_mm: 0, object_number: 1, degenerate: 1}},
        '{65535, 0, 0, '0}, '{3000, 0, 0, '0}, '{3010, 0, 0, '0}, '{2990, 0, 0, '0},
        '{3005, 0, 0, '0}, '{3000, 1, 0, '0},
        '{0, 1, 0, '0},
        '{65535, 0, 0, '0}, '{0, 0, 0, '0}, '{0, 0, 0, '0}, '{65535, 0, 0, '0},
        '{65535, 0, 0, '0}, '{64000, 0, 0, '0}, '{64100, 0, 0, '0}, '{63900, 0, 0, '0},
        '{64000, 1, 0, '0}
    };

    initial begin
        t_cfg c;
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_in = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        cycles = 0;
        errors = 0; n_samples = 0; n_centers = 0; n_degen = 0; n_writes = 0;
        sender_pct = 35; receiver_pct = 68;
        regs = '{edge_threshold_mm: 600, fill_threshold_mm: 400, min_range_mm: 250,
                 side_margin: 200, scan_length: 666, angle_start: -125818,
                 angle_step: 377, min_points: 9};
        clear_scan_state();
        foreach (seg_store[k]) seg_store[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero min range, one-sample margin, clusters of three or more
        c = regs;
        c.min_range_mm = 0; c.side_margin = 1; c.scan_length = 1023; c.min_points = 2;
        load_registers(c);
        foreach (rows[k])
            send_sample('{range_mm: rows[k].rng, last_sample: rows[k].last},
                        rows[k].typed, rows[k].ctr);
        end_samples();

        // receiver stalls more than sender idles
        run_phase(random_regs(), 50);
        c = random_regs();
        c.edge_threshold_mm = 0; c.fill_threshold_mm = 65535;
        run_phase(c, 40);
        c = random_regs();
        c.edge_threshold_mm = 65535; c.min_range_mm = 65535; c.fill_threshold_mm = 0;
        run_phase(c, 30);

        // sender idles more than receiver stalls
        sender_pct = 68; receiver_pct = 35;
        c = random_regs();
        c.side_margin = 1023; c.scan_length = 1;        // no valid window
        run_phase(c, 30);
        c = random_regs();
        c.side_margin = 0; c.scan_length = 1024;
        c.angle_start = -411775; c.angle_step = 65535; c.min_points = 0;
        run_phase(c, 50);
        c = random_regs();
        c.angle_start = 411775; c.angle_step = 0;
        run_phase(c, 30);
        c = random_regs();
        c.min_points = 255;
        run_phase(c, 30);

        // no idling
        sender_pct = 0; receiver_pct = 0;
        run_phase(random_regs(), 50);

        // long scan past the index limit, last flag only at the end; one-point
        // clusters back to back run the object number to saturation
        c = random_regs();
        c.edge_threshold_mm = 600; c.fill_threshold_mm = 400; c.min_range_mm = 0;
        c.side_margin = 1; c.scan_length = 1024; c.min_points = 0;
        load_registers(c);
        for (int k = 0; k < 1030; k++)
            send_sample('{range_mm: (k % 2) ? 16'(1000 + k) : 16'd5000,
                          last_sample: k == 1029});
        end_samples();

        while (centers_due.size() != 0) @(posedge i_clk);
        repeat (FIT_SETTLE) @(posedge i_clk);

        $display("%0d samples, %0d centers (%0d degenerate), %0d register writes",
                 n_samples, n_centers, n_degen, n_writes);
        $display("%0d cycles across ten register settings and three idle mixes", cycles);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
